// File: src/midi_track_event_parser_assert.svh
// Assertion macros shared by the parser modules.
// Each macro expects clk and rst_n in scope.
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define MTEP_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define MTEP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/midi_tep_pkg.sv
// ----------------------------------------------------------------------------
// midi_tep_pkg
// Shared types and codes of the MIDI track event parser.
// ----------------------------------------------------------------------------
package midi_tep_pkg;

    localparam int DELTA_BITS_DEFAULT = 28;

    localparam logic [7:0] STATUS_META  = 8'hFF;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_TIMESIG = 8'h58;
    localparam logic [7:0] META_KEYSIG  = 8'h59;
    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_PRESSURE  = 4'hD;
    localparam logic [3:0] HI_SYSTEM    = 4'hF;

    typedef enum logic [3:0] {
        PH_DELTA   = 4'd0,
        PH_STATUS  = 4'd1,
        PH_DATA1   = 4'd2,
        PH_DATA2   = 4'd3,
        PH_TYPE    = 4'd4,
        PH_LEN     = 4'd5,
        PH_PAYLOAD = 4'd6
    } phase_t;

    typedef enum logic [2:0] {
        EV_MESSAGE = 3'd0,
        EV_SYSEX   = 3'd1,
        EV_META    = 3'd2,
        EV_TEMPO   = 3'd3,
        EV_TIMESIG = 3'd4,
        EV_KEYSIG  = 3'd5,
        EV_EOT     = 3'd6
    } event_kind_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [27:0] delta_time;
        logic [31:0] track_time;
        logic [7:0]  status_value;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [7:0]  meta_type;
        logic [7:0]  payload_zero;
        logic [7:0]  payload_one;
        logic [7:0]  payload_two;
        logic [23:0] tempo_us;
        logic [27:0] payload_length;
    } result_t;

endpackage

// File: src/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Standard MIDI file track event parser, one track byte per transfer.
// ----------------------------------------------------------------------------
// Feed the bytes of a track chunk in order, one per input transfer, with
// track_start set on the first byte of each track. The parser accepts one
// byte every clock cycle while in_stall is low; the whole step (delta or
// length accumulation, status decode with running status, payload capture)
// is combinational logic behind the parser state registers. A completed
// event is pushed into a two-entry result buffer when its last byte is
// transferred in; the output shows the head entry. Input keeps flowing while
// a result waits; in_stall rises only when both entries hold results not yet
// taken. Meta and sysex payloads report their first three bytes and their
// length; after an end-of-track event all bytes are dropped until track_start.
// ----------------------------------------------------------------------------
module midi_track_event_parser #(
    parameter int DELTA_BITS = midi_tep_pkg::DELTA_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        track_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [27:0] delta_time,
    output logic [31:0] track_time,
    output logic [7:0]  status_value,
    output logic [7:0]  data_first,
    output logic [7:0]  data_second,
    output logic [7:0]  meta_type,
    output logic [7:0]  payload_zero,
    output logic [7:0]  payload_one,
    output logic [7:0]  payload_two,
    output logic [23:0] tempo_us,
    output logic [27:0] payload_length
);

    logic                  in_xfer;
    logic                  out_xfer;
    logic                  res_valid;
    logic                  buf_full;
    midi_tep_pkg::result_t res_data;
    midi_tep_pkg::result_t out_data;

    // Hold input only while the result buffer has no free entry.
    assign in_stall = buf_full;
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    midi_tep_parser #(
        .DELTA_BITS (DELTA_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_xfer     (in_xfer),
        .in_byte     (in_byte),
        .track_start (track_start),
        .res_valid   (res_valid),
        .res_data    (res_data)
    );

    midi_tep_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .din       (res_data),
        .pop       (out_xfer),
        .full      (buf_full),
        .not_empty (out_valid),
        .dout      (out_data)
    );

    // Unpack the head result onto the output ports.
    assign event_kind     = out_data.event_kind;
    assign delta_time     = out_data.delta_time;
    assign track_time     = out_data.track_time;
    assign status_value   = out_data.status_value;
    assign data_first     = out_data.data_first;
    assign data_second    = out_data.data_second;
    assign meta_type      = out_data.meta_type;
    assign payload_zero   = out_data.payload_zero;
    assign payload_one    = out_data.payload_one;
    assign payload_two    = out_data.payload_two;
    assign tempo_us       = out_data.tempo_us;
    assign payload_length = out_data.payload_length;

endmodule

// File: src/midi_tep_parser.sv
// ----------------------------------------------------------------------------
// midi_tep_parser
// Parser state and single-byte step logic; one byte per transfer.
// ----------------------------------------------------------------------------
`include "midi_track_event_parser_assert.svh"

module midi_tep_parser #(
    parameter int DELTA_BITS = midi_tep_pkg::DELTA_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_xfer,
    input  logic [7:0]              in_byte,
    input  logic                    track_start,
    output logic                    res_valid,
    output midi_tep_pkg::result_t   res_data
);

    midi_tep_pkg::phase_t     phase_reg, phase_next, phase_c;
    logic [7:0]               rs_reg, rs_next, rs_c;
    logic [DELTA_BITS-1:0]    delta_reg, delta_next, delta_c;
    logic [31:0]              time_reg, time_next, time_c;
    logic [7:0]               held_reg, held_next, held_c;
    logic [27:0]              len_reg, len_next, len_c;
    logic [27:0]              left_reg, left_next, left_c;
    logic [7:0]               meta_reg, meta_next, meta_c;
    logic [7:0]               pay_reg [3];
    logic [7:0]               pay_next [3];
    logic [7:0]               pay_c [3];
    logic                     done_reg, done_next, done_c;

    logic                      emit;
    logic                      with_pl;
    midi_tep_pkg::event_kind_t ekind;
    logic [7:0]                estat;
    logic [7:0]                ed1;
    logic [7:0]                ed2;
    logic [27:0]               idx;
    logic [31:0]               delta_ext;
    logic [31:0]               time_sum;

    function automatic logic one_data(input logic [7:0] status);
        return (status[7:4] == midi_tep_pkg::HI_PROGRAM) ||
               (status[7:4] == midi_tep_pkg::HI_PRESSURE);
    endfunction

    function automatic midi_tep_pkg::event_kind_t long_kind(input logic [7:0] held,
                                                             input logic [7:0] mtype);
        midi_tep_pkg::event_kind_t k;
        k = midi_tep_pkg::EV_SYSEX;
        if (held == midi_tep_pkg::STATUS_META)
        begin
            case (mtype)
                midi_tep_pkg::META_EOT:     k = midi_tep_pkg::EV_EOT;
                midi_tep_pkg::META_TEMPO:   k = midi_tep_pkg::EV_TEMPO;
                midi_tep_pkg::META_TIMESIG: k = midi_tep_pkg::EV_TIMESIG;
                midi_tep_pkg::META_KEYSIG:  k = midi_tep_pkg::EV_KEYSIG;
                default:                    k = midi_tep_pkg::EV_META;
            endcase
        end
        return k;
    endfunction

    always_comb
    begin
        // A track start clears the state before the byte is used.
        phase_c = track_start ? midi_tep_pkg::PH_DELTA : phase_reg;
        rs_c    = track_start ? 8'd0 : rs_reg;
        delta_c = track_start ? '0 : delta_reg;
        time_c  = track_start ? 32'd0 : time_reg;
        held_c  = track_start ? 8'd0 : held_reg;
        len_c   = track_start ? 28'd0 : len_reg;
        left_c  = track_start ? 28'd0 : left_reg;
        meta_c  = track_start ? 8'd0 : meta_reg;
        done_c  = track_start ? 1'b0 : done_reg;
        for (int i = 0; i < 3; i++)
        begin
            pay_c[i] = track_start ? 8'd0 : pay_reg[i];
        end

        phase_next = phase_c;
        rs_next    = rs_c;
        delta_next = delta_c;
        held_next  = held_c;
        len_next   = len_c;
        left_next  = left_c;
        meta_next  = meta_c;
        done_next  = done_c;
        pay_next   = pay_c;

        emit    = 1'b0;
        with_pl = 1'b0;
        ekind   = midi_tep_pkg::EV_MESSAGE;
        estat   = 8'd0;
        ed1     = 8'd0;
        ed2     = 8'd0;
        idx     = len_c - left_c;

        if (!done_c)
        begin
            case (phase_c)
                midi_tep_pkg::PH_STATUS:
                begin
                    if (in_byte == midi_tep_pkg::STATUS_META)
                    begin
                        held_next  = in_byte;
                        phase_next = midi_tep_pkg::PH_TYPE;
                    end
                    else if (in_byte == midi_tep_pkg::SYSEX_START ||
                             in_byte == midi_tep_pkg::SYSEX_ESCAPE)
                    begin
                        held_next  = in_byte;
                        meta_next  = 8'd0;
                        len_next   = 28'd0;
                        pay_next   = '{default: 8'd0};
                        phase_next = midi_tep_pkg::PH_LEN;
                    end
                    else if (in_byte[7])
                    begin
                        rs_next = in_byte;
                        if (in_byte[7:4] == midi_tep_pkg::HI_SYSTEM)
                        begin
                            emit       = 1'b1;
                            estat      = in_byte;
                            delta_next = '0;
                            phase_next = midi_tep_pkg::PH_DELTA;
                        end
                        else
                        begin
                            phase_next = midi_tep_pkg::PH_DATA1;
                        end
                    end
                    else if (rs_c[7:4] == midi_tep_pkg::HI_SYSTEM)
                    begin
                        // Data byte under a system status: emit, then take the
                        // byte as a one-byte delta for the next event.
                        emit       = 1'b1;
                        estat      = rs_c;
                        delta_next = DELTA_BITS'(in_byte);
                        phase_next = midi_tep_pkg::PH_STATUS;
                    end
                    else if (one_data(rs_c))
                    begin
                        emit       = 1'b1;
                        estat      = rs_c;
                        ed1        = in_byte;
                        delta_next = '0;
                        phase_next = midi_tep_pkg::PH_DELTA;
                    end
                    else
                    begin
                        held_next  = in_byte;
                        phase_next = midi_tep_pkg::PH_DATA2;
                    end
                end
                midi_tep_pkg::PH_DATA1:
                begin
                    if (one_data(rs_c))
                    begin
                        emit       = 1'b1;
                        estat      = rs_c;
                        ed1        = in_byte;
                        delta_next = '0;
                        phase_next = midi_tep_pkg::PH_DELTA;
                    end
                    else
                    begin
                        held_next  = in_byte;
                        phase_next = midi_tep_pkg::PH_DATA2;
                    end
                end
                midi_tep_pkg::PH_DATA2:
                begin
                    emit       = 1'b1;
                    estat      = rs_c;
                    ed1        = held_c;
                    ed2        = in_byte;
                    delta_next = '0;
                    phase_next = midi_tep_pkg::PH_DELTA;
                end
                midi_tep_pkg::PH_TYPE:
                begin
                    meta_next  = in_byte;
                    len_next   = 28'd0;
                    pay_next   = '{default: 8'd0};
                    phase_next = midi_tep_pkg::PH_LEN;
                end
                midi_tep_pkg::PH_LEN:
                begin
                    len_next = {len_c[20:0], in_byte[6:0]};
                    if (!in_byte[7])
                    begin
                        left_next = len_next;
                        if (len_next == 28'd0)
                        begin
                            emit       = 1'b1;
                            with_pl    = 1'b1;
                            ekind      = long_kind(held_c, meta_c);
                            estat      = held_c;
                            delta_next = '0;
                            phase_next = midi_tep_pkg::PH_DELTA;
                            done_next  = (ekind == midi_tep_pkg::EV_EOT);
                        end
                        else
                        begin
                            phase_next = midi_tep_pkg::PH_PAYLOAD;
                        end
                    end
                end
                midi_tep_pkg::PH_PAYLOAD:
                begin
                    if (idx < 28'd3)
                    begin
                        pay_next[idx[1:0]] = in_byte;
                    end
                    left_next = left_c - 28'd1;
                    if (left_next == 28'd0)
                    begin
                        emit       = 1'b1;
                        with_pl    = 1'b1;
                        ekind      = long_kind(held_c, meta_c);
                        estat      = held_c;
                        delta_next = '0;
                        phase_next = midi_tep_pkg::PH_DELTA;
                        done_next  = (ekind == midi_tep_pkg::EV_EOT);
                    end
                end
                default:
                begin
                    // Delta phase, and any unknown phase.
                    delta_next = {delta_c[DELTA_BITS-8:0], in_byte[6:0]};
                    phase_next = in_byte[7] ? midi_tep_pkg::PH_DELTA
                                            : midi_tep_pkg::PH_STATUS;
                end
            endcase
        end

        delta_ext = 32'(delta_c);
        time_sum  = time_c + delta_ext;
        time_next = emit ? time_sum : time_c;

        res_valid                   = in_xfer && emit;
        res_data.event_kind         = ekind;
        res_data.delta_time         = delta_ext[27:0];
        res_data.track_time         = time_sum;
        res_data.status_value       = estat;
        res_data.data_first         = ed1;
        res_data.data_second        = ed2;
        res_data.meta_type          = (with_pl && held_c == midi_tep_pkg::STATUS_META)
                                      ? meta_next : 8'd0;
        res_data.payload_zero       = with_pl ? pay_next[0] : 8'd0;
        res_data.payload_one        = with_pl ? pay_next[1] : 8'd0;
        res_data.payload_two        = with_pl ? pay_next[2] : 8'd0;
        res_data.tempo_us           = with_pl ? {pay_next[0], pay_next[1], pay_next[2]}
                                              : 24'd0;
        res_data.payload_length     = with_pl ? len_next : 28'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= midi_tep_pkg::PH_DELTA;
            rs_reg    <= 8'd0;
            delta_reg <= '0;
            time_reg  <= 32'd0;
            held_reg  <= 8'd0;
            len_reg   <= 28'd0;
            left_reg  <= 28'd0;
            meta_reg  <= 8'd0;
            pay_reg   <= '{default: 8'd0};
            done_reg  <= 1'b0;
        end
        else if (in_xfer)
        begin
            phase_reg <= phase_next;
            rs_reg    <= rs_next;
            delta_reg <= delta_next;
            time_reg  <= time_next;
            held_reg  <= held_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            meta_reg  <= meta_next;
            pay_reg   <= pay_next;
            done_reg  <= done_next;
        end
    end

    `MTEP_ASSERT_ALWAYS(a_done_silent, !(done_reg && in_xfer && !track_start && res_valid), "result after end of track")
    `MTEP_ASSERT_ALWAYS(a_emit_phase, !res_valid || phase_next == midi_tep_pkg::PH_DELTA || phase_next == midi_tep_pkg::PH_STATUS, "emit left parser mid-event")
    `MTEP_ASSERT_NEXT(a_eot_stops, res_valid && res_data.event_kind == midi_tep_pkg::EV_EOT, done_reg, "end of track did not stop parsing")

endmodule

// File: src/midi_tep_out_fifo.sv
// ----------------------------------------------------------------------------
// midi_tep_out_fifo
// Two-entry result buffer between the parser and the output channel.
// ----------------------------------------------------------------------------
`include "midi_track_event_parser_assert.svh"

module midi_tep_out_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  midi_tep_pkg::result_t   din,
    input  logic                    pop,
    output logic                    full,
    output logic                    not_empty,
    output midi_tep_pkg::result_t   dout
);

    midi_tep_pkg::result_t slot0_reg, slot0_next;
    midi_tep_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]            count_reg, count_next;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    slot0_next = din;
                end
                else
                begin
                    slot1_next = din;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    slot0_next = din;
                end
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = din;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign dout      = slot0_reg;

    `MTEP_ASSERT_ALWAYS(a_count_range, count_reg != 2'd3, "result buffer count out of range")
    `MTEP_ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into full result buffer")
    `MTEP_ASSERT_NEXT(a_advance, pop && !push && count_reg == 2'd2, slot0_reg == $past(slot1_reg), "result buffer did not advance")

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb - MIDI track event parser testbench
// Streams track bytes into the parser under random input gaps and output
// stalls. A behavioral parser predicts each completed event, and every
// event is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import midi_tep_pkg::*;

    // Ranges of status bytes used to build well-formed events.
    localparam logic [7:0] CHANNEL_FIRST = 8'h80;
    localparam logic [7:0] CHANNEL_LAST  = 8'hEF;
    localparam logic [7:0] SYSTEM_FIRST  = 8'hF1;
    localparam logic [7:0] SYSTEM_LAST   = 8'hFE;
    localparam logic [7:0] META_TEXT     = 8'h01;

    localparam int DELTA_W        = DELTA_BITS_DEFAULT;
    localparam int RANDOM_BYTES   = 1560;
    localparam int CYCLE_LIMIT    = 1500000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int REPORT_LINES   = 40;

    typedef struct packed {
        logic [7:0] value;
        logic       start;
    } track_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        track_start = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  event_kind;
    logic [27:0] delta_time;
    logic [31:0] track_time;
    logic [7:0]  status_value;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [7:0]  meta_type;
    logic [7:0]  payload_zero;
    logic [7:0]  payload_one;
    logic [7:0]  payload_two;
    logic [23:0] tempo_us;
    logic [27:0] payload_length;

    midi_track_event_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .track_start    (track_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .delta_time     (delta_time),
        .track_time     (track_time),
        .status_value   (status_value),
        .data_first     (data_first),
        .data_second    (data_second),
        .meta_type      (meta_type),
        .payload_zero   (payload_zero),
        .payload_one    (payload_one),
        .payload_two    (payload_two),
        .tempo_us       (tempo_us),
        .payload_length (payload_length)
    );

    // ------------------------------------------------------------------------
    // Stores and counters
    // ------------------------------------------------------------------------
    track_byte_t track_bytes_q[$];     // bytes waiting to be transferred in
    result_t     pending_events[$];    // predicted events not yet seen

    int  mismatch_count = 0;
    int  events_checked = 0;
    int  bytes_parsed = 0;
    int  tracks_started = 0;
    int  cycle_count = 0;
    int  kind_seen [8];

    // Driver and idling state
    logic        in_took = 1'b0;
    track_byte_t next_byte;
    int          gap_left = 0;
    int          free_left = 0;
    int          stall_left = 0;

    // Stimulus builder state
    logic        start_pending = 1'b0;
    logic [7:0]  gen_status = 8'h00;
    logic        big_mode = 1'b0;
    int          fed_count = 0;

    // ------------------------------------------------------------------------
    // Behavioral parser: its own copy of the parse state
    // ------------------------------------------------------------------------
    phase_t      ph;
    logic [7:0]  run_status;
    logic [31:0] delta_acc;
    logic [31:0] time_acc;
    logic [7:0]  held_byte;
    logic [27:0] len_acc;
    logic [27:0] remain;
    logic [7:0]  held_type;
    logic [7:0]  pay [0:2];
    logic        eot_seen;

    function automatic logic [31:0] delta_mask();
        return (DELTA_W >= 32) ? 32'hFFFF_FFFF : ((32'd1 << DELTA_W) - 32'd1);
    endfunction

    // Program change and channel pressure carry one data byte, all else two.
    function automatic logic one_data(input logic [7:0] status);
        return (status[7:4] == HI_PROGRAM) || (status[7:4] == HI_PRESSURE);
    endfunction

    task automatic clear_parser();
        ph = PH_DELTA;
        run_status = 8'h00;
        delta_acc = 32'd0;
        time_acc = 32'd0;
        held_byte = 8'h00;
        len_acc = 28'd0;
        remain = 28'd0;
        held_type = 8'h00;
        pay[0] = 8'h00;
        pay[1] = 8'h00;
        pay[2] = 8'h00;
        eot_seen = 1'b0;
    endtask

    // Close one event: advance track time, queue the expected result and
    // return to the delta phase.
    task automatic post_event(input event_kind_t kind, input logic [7:0] status,
                              input logic [7:0] d1, input logic [7:0] d2,
                              input logic long_form);
        result_t r;
        time_acc = time_acc + (delta_acc & delta_mask());
        r = '0;
        r.event_kind   = kind;
        r.delta_time   = 28'(delta_acc & delta_mask());
        r.track_time   = time_acc;
        r.status_value = status;
        r.data_first   = d1;
        r.data_second  = d2;
        if (long_form)
        begin
            r.meta_type      = (status == STATUS_META) ? held_type : 8'h00;
            r.payload_zero   = pay[0];
            r.payload_one    = pay[1];
            r.payload_two    = pay[2];
            r.tempo_us       = {pay[0], pay[1], pay[2]};
            r.payload_length = len_acc;
        end
        pending_events.push_back(r);
        delta_acc = 32'd0;
        ph = PH_DELTA;
    endtask

    // Close a meta or sysex event; end of track freezes the parser.
    task automatic finish_long();
        event_kind_t kind;
        kind = EV_SYSEX;
        if (held_byte == STATUS_META)
        begin
            case (held_type)
                META_EOT:     kind = EV_EOT;
                META_TEMPO:   kind = EV_TEMPO;
                META_TIMESIG: kind = EV_TIMESIG;
                META_KEYSIG:  kind = EV_KEYSIG;
                default:      kind = EV_META;
            endcase
        end
        post_event(kind, held_byte, 8'h00, 8'h00, 1'b1);
        if (kind == EV_EOT)
            eot_seen = 1'b1;
    endtask

    // Advance the behavioral parser by one transferred byte.
    task automatic parse_track_byte(input logic [7:0] b, input logic ts);
        logic [27:0] pos;
        bytes_parsed++;
        if (ts)
        begin
            clear_parser();
            tracks_started++;
        end
        if (!eot_seen)
        begin
            case (ph)
                PH_STATUS:
                begin
                    if (b == STATUS_META)
                    begin
                        held_byte = b;
                        ph = PH_TYPE;
                    end
                    else if (b == SYSEX_START || b == SYSEX_ESCAPE)
                    begin
                        held_byte = b;
                        held_type = 8'h00;
                        len_acc = 28'd0;
                        pay[0] = 8'h00;
                        pay[1] = 8'h00;
                        pay[2] = 8'h00;
                        ph = PH_LEN;
                    end
                    else if (b[7])
                    begin
                        run_status = b;
                        if (b[7:4] == HI_SYSTEM)
                            post_event(EV_MESSAGE, b, 8'h00, 8'h00, 1'b0);
                        else
                            ph = PH_DATA1;
                    end
                    else if (run_status[7:4] == HI_SYSTEM)
                    begin
                        // The data byte closes the system message and is
                        // itself the whole delta of the next event.
                        post_event(EV_MESSAGE, run_status, 8'h00, 8'h00, 1'b0);
                        delta_acc = {24'd0, b};
                        ph = PH_STATUS;
                    end
                    else if (one_data(run_status))
                        post_event(EV_MESSAGE, run_status, b, 8'h00, 1'b0);
                    else
                    begin
                        held_byte = b;
                        ph = PH_DATA2;
                    end
                end
                PH_DATA1:
                begin
                    if (one_data(run_status))
                        post_event(EV_MESSAGE, run_status, b, 8'h00, 1'b0);
                    else
                    begin
                        held_byte = b;
                        ph = PH_DATA2;
                    end
                end
                PH_DATA2:
                    post_event(EV_MESSAGE, run_status, held_byte, b, 1'b0);
                PH_TYPE:
                begin
                    held_type = b;
                    len_acc = 28'd0;
                    pay[0] = 8'h00;
                    pay[1] = 8'h00;
                    pay[2] = 8'h00;
                    ph = PH_LEN;
                end
                PH_LEN:
                begin
                    len_acc = {len_acc[20:0], b[6:0]};
                    if (!b[7])
                    begin
                        remain = len_acc;
                        if (remain == 28'd0)
                            finish_long();
                        else
                            ph = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    pos = len_acc - remain;
                    if (pos < 28'd3)
                        pay[pos[1:0]] = b;
                    remain = remain - 28'd1;
                    if (remain == 28'd0)
                        finish_long();
                end
                default:
                begin
                    delta_acc = ((delta_acc << 7) | {25'd0, b[6:0]}) & delta_mask();
                    ph = b[7] ? PH_DELTA : PH_STATUS;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_LINES)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("event %0d %s got %h expected %h",
                                      events_checked, name, got, want));
    endtask

    task automatic check_event();
        result_t want;
        if (pending_events.size() == 0)
        begin
            report_mismatch($sformatf("event of kind %0d with nothing expected",
                                      event_kind));
            return;
        end
        want = pending_events.pop_front();
        kind_seen[want.event_kind]++;
        check_field("event_kind", 32'(event_kind), 32'(want.event_kind));
        check_field("delta_time", 32'(delta_time), 32'(want.delta_time));
        check_field("track_time", track_time, want.track_time);
        check_field("status_value", 32'(status_value), 32'(want.status_value));
        check_field("data_first", 32'(data_first), 32'(want.data_first));
        check_field("data_second", 32'(data_second), 32'(want.data_second));
        check_field("meta_type", 32'(meta_type), 32'(want.meta_type));
        check_field("payload_zero", 32'(payload_zero), 32'(want.payload_zero));
        check_field("payload_one", 32'(payload_one), 32'(want.payload_one));
        check_field("payload_two", 32'(payload_two), 32'(want.payload_two));
        check_field("tempo_us", 32'(tempo_us), 32'(want.tempo_us));
        check_field("payload_length", 32'(payload_length), 32'(want.payload_length));
        events_checked++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        track_bytes_q.push_back('{value: b, start: start_pending});
        start_pending = 1'b0;
        fed_count++;
    endtask

    // Variable-length number in n groups of seven bits, most significant
    // first; n = 5 carries bits the parser must shift out.
    task automatic push_vlq(input logic [34:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            push_byte({i != 0, v[7*i +: 7]});
    endtask

    function automatic int vlq_size(input logic [27:0] v);
        int n;
        n = 1;
        while (n < 4 && (v >> (7 * n)) != 28'd0)
            n++;
        return n;
    endfunction

    task automatic push_delta();
        int r;
        logic [34:0] v;
        r = $urandom_range(0, 99);
        v = 35'd0;
        if (big_mode && r < 80)
            push_vlq(35'h0FFF_FFFF, 4);
        else if (r < 65)
            push_vlq(35'($urandom_range(0, 127)), 1);
        else if (r < 80)
            push_vlq(35'($urandom_range(128, 16383)), 2);
        else if (r < 90)
        begin
            v[27:0] = 28'($urandom);
            push_vlq(v, $urandom_range(vlq_size(v[27:0]), 4));
        end
        else if (r < 95)
            push_vlq(35'h0FFF_FFFF, 4);
        else
        begin
            v[27:0] = 28'($urandom);
            v[34:28] = 7'($urandom_range(1, 127));
            push_vlq(v, 5);
        end
    endtask

    // Length field: mostly minimal, some padded with leading zero groups,
    // a few over-long with junk above bit 27.
    task automatic push_length(input int len);
        int r;
        logic [34:0] v;
        r = $urandom_range(0, 99);
        v = 35'(len);
        if (r < 85)
            push_vlq(v, vlq_size(v[27:0]));
        else if (r < 95)
            push_vlq(v, $urandom_range(vlq_size(v[27:0]), 4));
        else
        begin
            v[34:28] = 7'($urandom_range(1, 127));
            push_vlq(v, 5);
        end
    endtask

    function automatic int pick_payload_len();
        return ($urandom_range(0, 99) < 90) ? $urandom_range(0, 8) : $urandom_range(9, 40);
    endfunction

    function automatic logic [7:0] data_byte();
        return ($urandom_range(0, 99) < 15) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 127));
    endfunction

    // Meta or sysex event body with random payload.
    task automatic send_long(input logic [7:0] lead, input logic [7:0] mtype,
                             input int len);
        push_byte(lead);
        if (lead == STATUS_META)
            push_byte(mtype);
        push_length(len);
        repeat (len)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    // Body under the current running status. Under a system status the
    // single data byte doubles as the next delta, so report that.
    task automatic send_running(output logic delta_done);
        delta_done = 1'b0;
        if (gen_status[7:4] == HI_SYSTEM)
        begin
            push_byte(8'($urandom_range(0, 127)));
            delta_done = 1'b1;
        end
        else
        begin
            push_byte(8'($urandom_range(0, 127)));
            if (!one_data(gen_status))
                push_byte(data_byte());
        end
    endtask

    task automatic new_track();
        start_pending = 1'b1;
        gen_status = 8'h00;
        big_mode = ($urandom_range(0, 7) == 0);
    endtask

    // Short directed pass through the corner cases.
    task automatic build_directed();
        start_pending = 1'b1;
        // running status before any status byte
        push_byte(8'h00); push_byte(8'h3C); push_byte(8'h40);
        push_byte(8'h7F); push_byte(8'h90); push_byte(8'h3C); push_byte(8'h7F);
        // largest delta, then running note on
        push_vlq(35'h0FFF_FFFF, 4); push_byte(8'h3E); push_byte(8'h00);
        // over-long delta, program change with a data byte that has bit 7 set
        push_vlq({7'h7F, 28'd5}, 5); push_byte(8'hC5); push_byte(8'h85);
        push_byte(8'h00); push_byte(8'hD2); push_byte(8'h7F);
        push_byte(8'h01); push_byte(8'h45);
        push_byte(8'h00); push_byte(8'hE0); push_byte(8'hFF); push_byte(8'hFF);
        // system status emitted at once, then a data byte under it
        push_byte(8'h00); push_byte(8'hF8);
        push_byte(8'h00); push_byte(8'h05);
        push_byte(8'hA0); push_byte(8'h10); push_byte(8'h20);
        push_byte(8'h00); send_long(STATUS_META, META_TEMPO, 3);
        push_byte(8'h00); send_long(STATUS_META, META_TIMESIG, 4);
        push_byte(8'h00); send_long(STATUS_META, META_KEYSIG, 2);
        push_byte(8'h00); send_long(STATUS_META, META_TEXT, 0);
        // meta length with junk above bit 27
        push_byte(8'h00); push_byte(STATUS_META); push_byte(8'h03);
        push_vlq({7'h70, 28'd2}, 5); push_byte(8'h41); push_byte(8'h42);
        push_byte(8'h00); send_long(SYSEX_START, 8'h00, 0);
        push_byte(8'h00); send_long(SYSEX_ESCAPE, 8'h00, 5);
        push_vlq(35'd200, 2); send_long(STATUS_META, 8'h7F, 130);
        push_byte(8'h00); push_byte(8'hF1);
        push_byte(8'h00); push_byte(8'hFE);
        // end of track, then bytes that must be dropped
        push_byte(8'h00); push_byte(STATUS_META); push_byte(META_EOT); push_byte(8'h00);
        push_byte(8'h90); push_byte(STATUS_META); push_byte(META_EOT); push_byte(8'h00);
        fed_count -= 4;
        start_pending = 1'b1;
        push_byte(8'h00); push_byte(8'h80); push_byte(8'h3C); push_byte(8'h00);
        // track start cuts a message short
        push_byte(8'h00); push_byte(8'h90);
    endtask

    // Random tracks: mostly well-formed events with random content, some
    // noise and abrupt restarts.
    task automatic build_random();
        int target;
        int r;
        int n;
        logic need_delta;
        logic delta_done;
        logic [7:0] b;
        target = fed_count + RANDOM_BYTES;
        need_delta = 1'b1;
        new_track();
        while (fed_count < target)
        begin
            if (need_delta)
                push_delta();
            need_delta = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                b = 8'($urandom_range(CHANNEL_FIRST, CHANNEL_LAST));
                gen_status = b;
                push_byte(b);
                push_byte(data_byte());
                if (!one_data(b))
                    push_byte(data_byte());
            end
            else if (r < 50)
            begin
                send_running(delta_done);
                need_delta = !delta_done;
            end
            else if (r < 58)
            begin
                do
                    b = 8'($urandom_range(SYSTEM_FIRST, SYSTEM_LAST));
                while (b == SYSEX_ESCAPE);
                gen_status = b;
                push_byte(b);
            end
            else if (r < 80)
            begin
                n = $urandom_range(0, 99);
                if (n < 25)
                    send_long(STATUS_META, META_TEMPO,
                              ($urandom_range(0, 9) != 0) ? 3 : $urandom_range(0, 6));
                else if (n < 45)
                    send_long(STATUS_META, META_TIMESIG,
                              ($urandom_range(0, 9) != 0) ? 4 : $urandom_range(0, 6));
                else if (n < 60)
                    send_long(STATUS_META, META_KEYSIG,
                              ($urandom_range(0, 9) != 0) ? 2 : $urandom_range(0, 6));
                else
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == META_EOT)
                        b = META_TEXT;
                    send_long(STATUS_META, b, pick_payload_len());
                end
            end
            else if (r < 90)
                send_long(($urandom_range(0, 1) != 0) ? SYSEX_START : SYSEX_ESCAPE,
                          8'h00, pick_payload_len());
            else if (r < 94)
            begin
                send_long(STATUS_META, META_EOT,
                          ($urandom_range(0, 4) != 0) ? 0 : $urandom_range(1, 3));
                // trailing bytes are dropped and do not count
                n = $urandom_range(0, 5);
                repeat (n)
                    push_byte(8'($urandom_range(0, 255)));
                fed_count -= n;
                new_track();
            end
            else if (r < 97)
            begin
                // noise, then resync with a fresh track
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)));
                new_track();
            end
            else
                new_track();
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Idling: mostly short gaps, a few long ones, and free-running stretches.
    // ------------------------------------------------------------------------
    function automatic int next_gap();
        int r;
        if (free_left > 0)
        begin
            free_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            free_left = $urandom_range(30, 100);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: on the falling edge, hold the byte until its transfer, then
    // advance to the next one after the chosen gap.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (track_bytes_q.size() != 0)
            begin
                next_byte = track_bytes_q.pop_front();
                in_byte <= next_byte.value;
                track_start <= next_byte.start;
                in_valid <= 1'b1;
                gap_left = next_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output stall: randomly chosen stalled and open stretches of random length.
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 99) < 35)
        begin
            out_stall <= 1'b1;
            stall_left = next_gap() + 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = ($urandom_range(0, 99) < 5) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 6);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: on the rising edge, predict from each input transfer first,
    // then check each output transfer; a result always trails its last byte.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events still expected",
                     cycle_count, pending_events.size());
            $display("tb failed");
            $finish;
        end
        else
        begin
            in_took = rst_n && in_valid && !in_stall;
            if (in_took)
                parse_track_byte(in_byte, track_start);
            if (rst_n && out_valid && !out_stall)
                check_event();
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: build the stimulus, reset, drain, report.
    // ------------------------------------------------------------------------
    initial
    begin
        clear_parser();
        build_directed();
        build_random();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain on the falling edge, away from the monitor's updates.
        while (track_bytes_q.size() != 0 || in_valid)
            @(negedge clk);
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d track bytes over %0d track starts, %0d events checked",
                 bytes_parsed, tracks_started, events_checked);
        $display("mix: %0d msg, %0d sysex, %0d meta, %0d tempo, %0d timesig, %0d keysig, %0d eot",
                 kind_seen[EV_MESSAGE], kind_seen[EV_SYSEX], kind_seen[EV_META],
                 kind_seen[EV_TEMPO], kind_seen[EV_TIMESIG], kind_seen[EV_KEYSIG],
                 kind_seen[EV_EOT]);
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/midi_tep_pkg.sv
src/midi_tep_parser.sv
src/midi_tep_out_fifo.sv
src/midi_track_event_parser.sv
sim/tb.sv
